// File: rtl/prefix_code_decoder_defines.svh
// ----------------------------------------------------------------------------
// Prefix code decoder: assertion macros
// Shared macros for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_DECODER_DEFINES_SVH
`define PREFIX_CODE_DECODER_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define PCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that implies a consequence in the same cycle.
`define PCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// A condition that implies a consequence in the following cycle.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pcd_pkg.sv
// ----------------------------------------------------------------------------
// Prefix code decoder package
// Field widths, action and status codes, and the types passed between units.
// ----------------------------------------------------------------------------
package pcd_pkg;

	// Field widths of one input beat.
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 6;
	localparam int CODE_W   = 16;
	localparam int LENGTH_W = 5;
	localparam int SYMBOL_W = 16;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 2;

	// Width of the word length as reported to the checks (holds up to 63).
	localparam int WLEN_STAT_W = 6;

	// Input tdata layout, lowest field first.
	localparam int IN_DATA_W = 56;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 3;

	typedef logic [ACTION_W-1:0] action_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Actions carried on tuser.
	localparam action_t ACT_LOAD   = 2'd0;
	localparam action_t ACT_DECODE = 2'd1;
	localparam action_t ACT_END    = 2'd2;

	// Result status codes.
	localparam status_t ST_OK         = 2'd0;
	localparam status_t ST_NOT_BINARY = 2'd1;
	localparam status_t ST_MISSING    = 2'd2;
	localparam status_t ST_OVERFLOW   = 2'd3;

	// Signal characters.
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] CH_ONE  = 8'd49;

	// One result item as it travels through the queue.
	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                symbol_valid;
		status_t             status;
	} result_t;

	// Decoder state exposed to the checks.
	typedef struct packed {
		logic [WLEN_STAT_W-1:0] word_len;
		status_t                sticky;
	} front_stat_t;

endpackage

// File: rtl/prefix_code_decoder.sv
// ----------------------------------------------------------------------------
// Prefix code decoder
// Streams '0'/'1' characters through a loadable prefix-code table.
// ----------------------------------------------------------------------------
// The block takes one beat per clock unless the output stalls, and gives exactly
// one result beat for each via the stage one register, queue and back end. What
// sets the rate is the word register: each signal character is compared
// against all table entries in the same cycle, and the word is cleared or
// grown from that result before the next character. The table lives in
// flip-flops; reset clears every entry length at once, so no clearing pass
// follows reset. Load table entries with load beats before decoding; a load
// beat to an index beyond the table is dropped but still returns a result.
// ----------------------------------------------------------------------------
`include "prefix_code_decoder_defines.svh"

module prefix_code_decoder #(
	parameter int ENTRIES      = 64,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// entry_index, entry_code, entry_length, entry_symbol, signal_char
	input  logic [pcd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// action
	input  logic [pcd_pkg::ACTION_W-1:0]      s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// symbol
	output logic [pcd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// symbol_valid, status
	output logic [pcd_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

	logic                          fr_valid;
	logic                          fr_ready;
	pcd_pkg::result_t              fr_res;
	pcd_pkg::front_stat_t          fr_stat;
	logic                          q_valid;
	logic                          q_ready;
	pcd_pkg::result_t              q_res;
	pcd_pkg::result_t              bk_res;

	// Front end: table, word and classification.
	pcd_front #(
		.ENTRIES      (ENTRIES),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser),
		.in_index  (s_axis_tdata[5:0]),
		.in_code   (s_axis_tdata[21:6]),
		.in_length (s_axis_tdata[26:22]),
		.in_symbol (s_axis_tdata[42:27]),
		.in_char   (s_axis_tdata[50:43]),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_res   (fr_res),
		.stat      (fr_stat)
	);

	// Queue between the two halves.
	pcd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_res),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_res)
	);

	// Back end: output register.
	pcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_res    (q_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (bk_res)
	);

	// Pack the result beat.
	assign m_axis_tdata = bk_res.symbol;
	assign m_axis_tuser = {bk_res.status, bk_res.symbol_valid};

	// Checks.
	`PCD_ASSERT_ALWAYS(a_word_len_bound, fr_stat.word_len <= pcd_pkg::WLEN_STAT_W'(MAX_CODE_LEN), "word length beyond maximum code length")
	`PCD_ASSERT_ALWAYS(a_sticky_code, fr_stat.sticky != pcd_pkg::ST_MISSING, "missing digits held as sticky error")
	`PCD_ASSERT_NEXT(a_end_clears, s_axis_tvalid && s_axis_tready && s_axis_tuser == pcd_pkg::ACT_END, fr_stat.word_len == '0 && fr_stat.sticky == pcd_pkg::ST_OK, "end of message left word or error")
	`PCD_ASSERT_SAME(a_symbol_ok, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[2:1] == pcd_pkg::ST_OK, "decoded symbol carries an error status")

endmodule

// File: rtl/pcd_front.sv
// ----------------------------------------------------------------------------
// Prefix code decoder front end
// Holds the code table and the current word, classifies each beat, compares
// the grown word against every entry at once and selects the matched symbol.
// ----------------------------------------------------------------------------
module pcd_front #(
	parameter int ENTRIES      = 64,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  pcd_pkg::action_t              in_action,
	input  logic [pcd_pkg::INDEX_W-1:0]   in_index,
	input  logic [pcd_pkg::CODE_W-1:0]    in_code,
	input  logic [pcd_pkg::LENGTH_W-1:0]  in_length,
	input  logic [pcd_pkg::SYMBOL_W-1:0]  in_symbol,
	input  logic [pcd_pkg::CHAR_W-1:0]    in_char,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pcd_pkg::result_t              out_res,
	output pcd_pkg::front_stat_t          stat
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int LW = (LEN_W > pcd_pkg::LENGTH_W) ? LEN_W : pcd_pkg::LENGTH_W;
	localparam int CW = (MAX_CODE_LEN > pcd_pkg::CODE_W) ? MAX_CODE_LEN : pcd_pkg::CODE_W;

	// Code table.
	logic [pcd_pkg::CODE_W-1:0]   code_q [ENTRIES];
	logic [pcd_pkg::LENGTH_W-1:0] len_q  [ENTRIES];
	logic [pcd_pkg::SYMBOL_W-1:0] sym_q  [ENTRIES];

	// Word being assembled and the sticky error.
	logic [MAX_CODE_LEN-1:0] word_bits_q;
	logic [LEN_W-1:0]        word_len_q;
	pcd_pkg::status_t        sticky_q;

	// Stage one: match vector and status of the accepted beat.
	logic                 valid_s1;
	logic [ENTRIES-1:0]   match_s1;
	pcd_pkg::status_t     status_s1;

	logic                    accept;
	logic                    char_bin;
	logic                    new_bit;
	logic [MAX_CODE_LEN-1:0] next_bits;
	logic [LEN_W-1:0]        next_len;
	logic [CW-1:0]           len_mask;
	logic [CW-1:0]           bits_ext;
	logic [ENTRIES-1:0]      hit;
	logic                    any_hit;
	logic                    wr_en;
	logic [ENTRIES-1:0]      wr_sel;

	logic [MAX_CODE_LEN-1:0] word_bits_n;
	logic [LEN_W-1:0]        word_len_n;
	pcd_pkg::status_t        sticky_n;
	pcd_pkg::status_t        status_n;
	logic [ENTRIES-1:0]      match_n;

	logic [ENTRIES-1:0]           first_hit;
	logic [pcd_pkg::SYMBOL_W-1:0] sel_sym;

	// Handshake: stage one moves on whenever the queue can take its beat.
	assign in_ready = !valid_s1 || out_ready;
	assign accept   = in_valid && in_ready;

	// Word as it would stand with the new character appended.
	assign char_bin  = (in_char == pcd_pkg::CH_ZERO) || (in_char == pcd_pkg::CH_ONE);
	assign new_bit   = (in_char == pcd_pkg::CH_ONE);
	assign next_bits = MAX_CODE_LEN'({word_bits_q, new_bit});
	assign next_len  = word_len_q + LEN_W'(1);
	assign len_mask  = ~({CW{1'b1}} << next_len);
	assign bits_ext  = CW'(next_bits);

	// Parallel compare of the grown word against every table entry.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit[i] = (LW'(len_q[i]) == LW'(next_len))
				&& ((CW'(code_q[i]) & len_mask) == bits_ext);
		end
	end

	assign any_hit = |hit;

	// Classify the beat and work out the next decoder state.
	always_comb begin
		word_bits_n = word_bits_q;
		word_len_n  = word_len_q;
		sticky_n    = sticky_q;
		status_n    = pcd_pkg::ST_OK;
		match_n     = '0;
		wr_en       = 1'b0;
		unique case (in_action)
			pcd_pkg::ACT_LOAD: begin
				wr_en = 1'b1;
			end
			pcd_pkg::ACT_DECODE: begin
				if (sticky_q != pcd_pkg::ST_OK) begin
					status_n = sticky_q;
				end else if (!char_bin) begin
					sticky_n = pcd_pkg::ST_NOT_BINARY;
					status_n = pcd_pkg::ST_NOT_BINARY;
				end else if (word_len_q >= LEN_W'(MAX_CODE_LEN)) begin
					sticky_n = pcd_pkg::ST_OVERFLOW;
					status_n = pcd_pkg::ST_OVERFLOW;
				end else if (any_hit) begin
					word_bits_n = '0;
					word_len_n  = '0;
					match_n     = hit;
				end else begin
					word_bits_n = next_bits;
					word_len_n  = next_len;
				end
			end
			pcd_pkg::ACT_END: begin
				if (sticky_q != pcd_pkg::ST_OK) begin
					status_n = sticky_q;
				end else if (word_len_q != '0) begin
					status_n = pcd_pkg::ST_MISSING;
				end
				word_bits_n = '0;
				word_len_n  = '0;
				sticky_n    = pcd_pkg::ST_OK;
			end
			default: begin
			end
		endcase
	end

	// Slot select for a load; an index beyond the table selects nothing.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			wr_sel[i] = accept && wr_en && (32'(in_index) == 32'(i));
		end
	end

	// Entry lengths are cleared at reset, which marks every slot unused.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (wr_sel[i]) begin
					len_q[i] <= in_length;
				end
			end
		end
	end

	// Code and symbol fields only matter once the length is written.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_sel[i]) begin
				code_q[i] <= in_code;
				sym_q[i]  <= in_symbol;
			end
		end
	end

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bits_q <= '0;
			word_len_q  <= '0;
			sticky_q    <= pcd_pkg::ST_OK;
		end else if (accept) begin
			word_bits_q <= word_bits_n;
			word_len_q  <= word_len_n;
			sticky_q    <= sticky_n;
		end
	end

	// Stage one register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_s1  <= match_n;
			status_s1 <= status_n;
		end
	end

	// The lowest-numbered matching slot wins. The table cannot change while
	// a beat waits here, as no new beat is taken until it moves on.
	assign first_hit = match_s1 & (~match_s1 + ENTRIES'(1));

	always_comb begin
		sel_sym = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			sel_sym = sel_sym | (first_hit[i] ? sym_q[i] : '0);
		end
	end

	assign out_valid            = valid_s1;
	assign out_res.symbol       = sel_sym;
	assign out_res.symbol_valid = |match_s1;
	assign out_res.status       = status_s1;

	assign stat.word_len = pcd_pkg::WLEN_STAT_W'(word_len_q);
	assign stat.sticky   = sticky_q;

endmodule

// File: rtl/pcd_queue.sv
// ----------------------------------------------------------------------------
// Prefix code decoder result queue
// A short first-in first-out queue of result items between front and back.
// ----------------------------------------------------------------------------
module pcd_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  pcd_pkg::result_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output pcd_pkg::result_t pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	pcd_pkg::result_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic push;
	logic pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/pcd_back.sv
// ----------------------------------------------------------------------------
// Prefix code decoder back end
// Output register that delivers result beats; its ready towards the queue
// follows the downstream ready combinationally.
// ----------------------------------------------------------------------------
module pcd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pcd_pkg::result_t in_res,
	output logic             out_valid,
	input  logic             out_ready,
	output pcd_pkg::result_t out_res
);

	logic             valid_q;
	pcd_pkg::result_t res_q;

	// The register refills whenever it is empty or its beat is taken.
	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule
